/* design/amsm_pkg.sv */
// ---------------------------------------------------------------------------
// amsm_pkg: shared types and codes for the multi-pattern string matcher
// Operation codes, result kinds, sequencer states and fixed limits.
// ---------------------------------------------------------------------------
package amsm_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_BUILD  = 2'd1,
		OP_TEXT   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_NONE      = 2'd0,
		KIND_MATCH     = 2'd1,
		KIND_NODE_FULL = 2'd2,
		KIND_PAT_FULL  = 2'd3
	} kind_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISP,
		S_CS_RD,
		S_CS_CK,
		S_INS_DONE,
		S_INS_END,
		S_B_NODE,
		S_B_NCHK,
		S_B_F1,
		S_B_CHK,
		S_T_CHK,
		S_T_F,
		S_T_MATCH,
		S_T_CUR,
		S_T_PRD,
		S_T_PCK,
		S_T_FAIL,
		S_EMIT
	} state_t;

	// most results one text beat may return
	localparam int RESULT_CAP = 16;

endpackage

/* design/amsm_ram.sv */
// ---------------------------------------------------------------------------
// amsm_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module amsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* design/multi_pattern_string_matcher_top.sv */
// ---------------------------------------------------------------------------
// multi_pattern_string_matcher_top: Aho-Corasick byte matcher
// Trie insert, breadth-first failure-link build, text matching and clear, all
// run by one sequencer around a shared child-search compare unit.
// ---------------------------------------------------------------------------
// A child search scans the node store one node at a time, so a pattern byte
// costs one child search, a text byte one per failure-link hop plus a check
// of every pattern against each node of the fail chain, and a build one
// child search per failure step for every node. One beat at a time.
// Results leave through an output register; a new beat may start while it drains.
// Reset (arst_n low) empties the automaton: root only, no patterns.
module multi_pattern_string_matcher_top
	import amsm_pkg::*;
#(
	parameter int MAX_NODES    = 256,
	parameter int MAX_PATTERNS = 16,
	parameter int POS_BITS     = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [7:0]  byte_value,
	input  logic        last,
	input  logic        start_of_text,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [3:0]  pattern_id,
	output logic [31:0] start_pos,
	output logic        last_result
);

	localparam int NB  = $clog2(MAX_NODES);
	localparam int PB  = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
	localparam int NW  = 2 * NB + 8;
	localparam int SW  = POS_BITS + NB;
	localparam logic [NB:0] NODE_MAX = (NB + 1)'(MAX_NODES);
	localparam logic [PB:0] PAT_MAX  = (PB + 1)'(MAX_PATTERNS);
	localparam logic [4:0]  CAP      = 5'(RESULT_CAP);

	state_t state_q, state_d;

	// latched beat
	op_t        op_q;
	logic [7:0] c_q;
	logic       last_q;
	kind_t      kind_q;

	// automaton state
	logic [NB:0]         node_count_q;
	logic [NB-1:0]       max_depth_q;
	logic [PB:0]         pat_count_q;
	logic [NB-1:0]       ins_node_q;
	logic [NB-1:0]       ins_len_q;
	logic                ins_failed_q;
	logic [NB-1:0]       match_node_q;
	logic [POS_BITS-1:0] text_pos_q;
	logic [POS_BITS-1:0] cur_pos_q;

	// working registers
	logic [NB:0]   cs_j_q;
	logic [NB-1:0] s_q;
	logic [NB-1:0] ch_q;
	logic [NB-1:0] ch_depth_q;
	logic [NB:0]   bj_q;
	logic [NB-1:0] d_q;
	logic [NB-1:0] cur_q;
	logic [PB:0]   id_q;
	logic [4:0]    n_q;

	// pending match, held back until we know whether it is the final one
	logic          hold_v_q;
	logic [3:0]    hold_id_q;
	logic [31:0]   hold_start_q;

	// output register
	logic          out_v_q;
	kind_t         out_kind_q;
	logic [3:0]    out_id_q;
	logic [31:0]   out_start_q;
	logic          out_last_q;

	// memories
	logic          node_we, fail_we, pat_we;
	logic [NB-1:0] node_raddr, fail_raddr, fail_waddr, fail_wdata;
	logic [NW-1:0] node_wdata, node_rdata;
	logic [NB-1:0] fail_rdata;
	logic [2*NB-1:0] pat_wdata, pat_rdata;

	logic [NB-1:0] nd_parent, nd_depth;
	logic [7:0]    nd_byte;
	logic [NB-1:0] pt_end, pt_len;
	logic          out_free;
	logic          out_load;
	logic          cs_hit;
	logic [NB-1:0] new_depth;
	logic [NB-1:0] g_val;
	logic [SW-1:0] start_full;
	logic [POS_BITS+31:0] start_ext;
	logic [PB+4:0] id_ext;
	logic          pat_hit;
	state_t        cs_ret;

	assign {nd_parent, nd_byte, nd_depth} = node_rdata;
	assign {pt_end, pt_len}               = pat_rdata;
	assign out_free  = !out_v_q || out_ready;
	assign cs_hit    = (nd_parent == s_q) && (nd_byte == c_q);
	assign new_depth = ins_len_q + 1'b1;
	assign g_val     = (ch_q == bj_q[NB-1:0]) ? '0 : ch_q;
	assign pat_hit   = (pt_end == cur_q) && (n_q < CAP);

	// output register loads a held match or the final beat
	assign out_load  = ((state_q == S_T_PCK) && pat_hit && hold_v_q && out_free) ||
		((state_q == S_EMIT) && out_free);

	// start = position - length + 1, taken to 32 bits
	assign start_full = {{NB{1'b0}}, cur_pos_q} - {{POS_BITS{1'b0}}, pt_len} + 1'b1;
	assign start_ext  = {32'b0, start_full[POS_BITS-1:0]};
	assign id_ext     = {4'b0, id_q};

	always_comb begin
		case (op_q)
			OP_INSERT: cs_ret = S_INS_DONE;
			OP_BUILD:  cs_ret = S_B_CHK;
			default:   cs_ret = S_T_CHK;
		endcase
	end

	amsm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES), .AW(NB)) u_node_ram (
		.clk(clk), .we(node_we), .waddr(node_count_q[NB-1:0]), .wdata(node_wdata),
		.raddr(node_raddr), .rdata(node_rdata)
	);

	amsm_ram #(.WIDTH(NB), .DEPTH(MAX_NODES), .AW(NB)) u_fail_ram (
		.clk(clk), .we(fail_we), .waddr(fail_waddr), .wdata(fail_wdata),
		.raddr(fail_raddr), .rdata(fail_rdata)
	);

	amsm_ram #(.WIDTH(2 * NB), .DEPTH(MAX_PATTERNS), .AW(PB)) u_pat_ram (
		.clk(clk), .we(pat_we), .waddr(pat_count_q[PB-1:0]), .wdata(pat_wdata),
		.raddr(id_q[PB-1:0]), .rdata(pat_rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory controls
	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		node_we    = 1'b0;
		fail_we    = 1'b0;
		pat_we     = 1'b0;
		node_wdata = {ins_node_q, c_q, new_depth};
		pat_wdata  = {ins_node_q, ins_len_q};
		fail_waddr = bj_q[NB-1:0];
		fail_wdata = '0;
		node_raddr = cs_j_q[NB-1:0];
		fail_raddr = s_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (op_q)
					OP_INSERT: begin
						if (ins_failed_q || pat_count_q >= PAT_MAX) begin
							state_d = S_INS_END;
						end else begin
							state_d = S_CS_RD;
						end
					end
					OP_BUILD: state_d = S_B_NODE;
					OP_TEXT:  state_d = S_CS_RD;
					default:  state_d = S_EMIT;
				endcase
			end
			// shared child search: scan nodes 1..count-1 for (parent, byte)
			S_CS_RD: begin
				if (cs_j_q >= node_count_q) begin
					state_d = cs_ret;
				end else begin
					state_d = S_CS_CK;
				end
			end
			S_CS_CK: begin
				state_d = cs_hit ? cs_ret : S_CS_RD;
			end
			S_INS_DONE: begin
				if (ch_q == '0 && node_count_q < NODE_MAX) begin
					node_we    = 1'b1;
					fail_we    = 1'b1;
					fail_waddr = node_count_q[NB-1:0];
				end
				state_d = S_INS_END;
			end
			S_INS_END: begin
				if (last_q && !ins_failed_q && ins_len_q != '0 && pat_count_q < PAT_MAX) begin
					pat_we = 1'b1;
				end
				state_d = S_EMIT;
			end
			// failure-link build, level by level
			S_B_NODE: begin
				node_raddr = bj_q[NB-1:0];
				if (bj_q >= node_count_q && d_q >= max_depth_q) begin
					state_d = S_EMIT;
				end else if (bj_q < node_count_q) begin
					state_d = S_B_NCHK;
				end
			end
			S_B_NCHK: begin
				fail_raddr = nd_parent;
				if (nd_depth != d_q) begin
					state_d = S_B_NODE;
				end else if (d_q == NB'(1)) begin
					fail_we = 1'b1;
					state_d = S_B_NODE;
				end else begin
					state_d = S_B_F1;
				end
			end
			S_B_F1: state_d = S_CS_RD;
			S_B_CHK: begin
				if (ch_q != '0 || s_q == '0) begin
					fail_we    = 1'b1;
					fail_wdata = g_val;
					state_d    = S_B_NODE;
				end else begin
					state_d = S_B_F1;
				end
			end
			// text: follow failure links until a goto edge exists or the root is reached
			S_T_CHK: begin
				if (ch_q != '0 || s_q == '0) begin
					state_d = S_T_MATCH;
				end else begin
					state_d = S_T_F;
				end
			end
			S_T_F:     state_d = S_CS_RD;
			S_T_MATCH: state_d = S_T_CUR;
			S_T_CUR:   state_d = (cur_q == '0) ? S_EMIT : S_T_PRD;
			S_T_PRD: begin
				fail_raddr = cur_q;
				state_d = (id_q >= pat_count_q) ? S_T_FAIL : S_T_PCK;
			end
			S_T_PCK: begin
				if (!(pat_hit && hold_v_q && !out_free)) begin
					state_d = S_T_PRD;
				end
			end
			S_T_FAIL: state_d = S_T_CUR;
			S_EMIT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers of the automaton
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= (NB + 1)'(1);
			max_depth_q  <= '0;
			pat_count_q  <= '0;
			ins_node_q   <= '0;
			ins_len_q    <= '0;
			ins_failed_q <= 1'b0;
			match_node_q <= '0;
			text_pos_q   <= '0;
			hold_v_q     <= 1'b0;
			n_q          <= '0;
			out_v_q      <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					hold_v_q <= 1'b0;
					n_q      <= '0;
				end
				S_DISP: begin
					if (op_q == OP_INSERT && !ins_failed_q && pat_count_q >= PAT_MAX) begin
						ins_failed_q <= 1'b1;
					end
					if (op_q == OP_TEXT && last_q) begin
						match_node_q <= '0;
						text_pos_q   <= '0;
					end
					if (op_q == OP_CLEAR) begin
						node_count_q <= (NB + 1)'(1);
						max_depth_q  <= '0;
						pat_count_q  <= '0;
						ins_node_q   <= '0;
						ins_len_q    <= '0;
						ins_failed_q <= 1'b0;
						match_node_q <= '0;
						text_pos_q   <= '0;
					end
				end
				S_INS_DONE: begin
					if (ch_q != '0) begin
						ins_node_q <= ch_q;
						ins_len_q  <= ch_depth_q;
					end else if (node_count_q < NODE_MAX) begin
						ins_node_q   <= node_count_q[NB-1:0];
						ins_len_q    <= new_depth;
						node_count_q <= node_count_q + 1'b1;
						if (new_depth > max_depth_q) begin
							max_depth_q <= new_depth;
						end
					end else begin
						ins_failed_q <= 1'b1;
					end
				end
				S_INS_END: begin
					if (last_q) begin
						if (!ins_failed_q && ins_len_q != '0 && pat_count_q < PAT_MAX) begin
							pat_count_q <= pat_count_q + 1'b1;
						end
						ins_node_q   <= '0;
						ins_len_q    <= '0;
						ins_failed_q <= 1'b0;
					end
				end
				S_T_MATCH: begin
					match_node_q <= (ch_q != '0) ? ch_q : s_q;
					text_pos_q   <= text_pos_q + 1'b1;
				end
				S_T_PCK: begin
					if (pat_hit && (!hold_v_q || out_free)) begin
						hold_v_q <= 1'b1;
						n_q      <= n_q + 1'b1;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						hold_v_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q   <= op_t'(operation);
				c_q    <= byte_value;
				last_q <= (operation == OP_TEXT) ? start_of_text : last;
				kind_q <= KIND_NONE;
			end
			S_DISP: begin
				cs_j_q <= (NB + 1)'(1);
				bj_q   <= (NB + 1)'(1);
				d_q    <= NB'(1);
				ch_q   <= '0;
				id_q   <= '0;
				if (op_q == OP_INSERT) begin
					s_q <= ins_node_q;
					if (!ins_failed_q && pat_count_q >= PAT_MAX) begin
						kind_q <= KIND_PAT_FULL;
					end
				end else begin
					s_q <= last_q ? '0 : match_node_q;
				end
				if (op_q == OP_TEXT) begin
					cur_pos_q <= last_q ? '0 : text_pos_q;
				end
			end
			S_CS_RD: begin
				ch_q <= '0;
			end
			S_CS_CK: begin
				if (cs_hit) begin
					ch_q       <= cs_j_q[NB-1:0];
					ch_depth_q <= nd_depth;
				end else begin
					cs_j_q <= cs_j_q + 1'b1;
				end
			end
			S_INS_DONE: begin
				if (ch_q == '0 && node_count_q >= NODE_MAX) begin
					kind_q <= KIND_NODE_FULL;
				end
			end
			S_B_NODE: begin
				if (bj_q >= node_count_q) begin
					bj_q <= (NB + 1)'(1);
					d_q  <= d_q + 1'b1;
				end
			end
			S_B_NCHK: begin
				c_q <= nd_byte;
				if (nd_depth != d_q || d_q == NB'(1)) begin
					bj_q <= bj_q + 1'b1;
				end
			end
			S_B_F1, S_T_F: begin
				s_q    <= fail_rdata;
				cs_j_q <= (NB + 1)'(1);
			end
			S_B_CHK: begin
				if (ch_q != '0 || s_q == '0) begin
					bj_q <= bj_q + 1'b1;
				end
			end
			S_T_CHK: begin
				cur_q <= (ch_q != '0) ? ch_q : s_q;
			end
			S_T_CUR: begin
				id_q <= '0;
			end
			S_T_PCK: begin
				if (!pat_hit || !hold_v_q || out_free) begin
					id_q <= id_q + 1'b1;
				end
				if (pat_hit && (!hold_v_q || out_free)) begin
					hold_id_q    <= id_ext[3:0];
					hold_start_q <= start_ext[31:0];
				end
			end
			S_T_FAIL: begin
				cur_q <= fail_rdata;
			end
			default: ;
		endcase
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == S_T_PCK && pat_hit && hold_v_q && out_free) begin
			out_kind_q  <= KIND_MATCH;
			out_id_q    <= hold_id_q;
			out_start_q <= hold_start_q;
			out_last_q  <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			out_kind_q  <= hold_v_q ? KIND_MATCH : kind_q;
			out_id_q    <= hold_v_q ? hold_id_q : 4'd0;
			out_start_q <= hold_v_q ? hold_start_q : 32'd0;
			out_last_q  <= 1'b1;
		end
	end

	assign out_valid   = out_v_q;
	assign kind        = out_kind_q;
	assign pattern_id  = out_id_q;
	assign start_pos   = out_start_q;
	assign last_result = out_last_q;

`ifndef SYNTHESIS
	a_node_bound: assert property (@(posedge clk) disable iff (!arst_n)
		node_count_q <= NODE_MAX && node_count_q != '0)
		else $error("node count out of range");
	a_pat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pat_count_q <= PAT_MAX)
		else $error("pattern count out of range");
	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second beat taken while busy");
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CAP)
		else $error("result cap exceeded");
`endif

endmodule
